FILE: hdl/vlf_pkg.sv
// package for the vlan l2 learning forwarder: item types, table sizing and result codes
// used by the front, back and top modules; depends on nothing
`timescale 1ns / 1ps
package vlf_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int NUM_PORTS = 3;
  localparam int MAC_W = 48;
  localparam int VLAN_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [VLAN_W-1:0] PORT0_VLAN_RST = 12'd10;
  localparam logic [VLAN_W-1:0] PORT1_VLAN_RST = 12'd10;
  localparam logic [VLAN_W-1:0] PORT2_VLAN_RST = 12'd20;

  localparam logic [1:0] CFG_PORT0_VLAN = 2'd0;
  localparam logic [1:0] CFG_PORT1_VLAN = 2'd1;
  localparam logic [1:0] CFG_PORT2_VLAN = 2'd2;

  localparam logic [1:0] HOST_PORT = 2'd3;

  localparam logic [2:0] DISP_FWD      = 3'd0;
  localparam logic [2:0] DISP_FLOOD    = 3'd1;
  localparam logic [2:0] DISP_SAMEPORT = 3'd2;
  localparam logic [2:0] DISP_VLANDROP = 3'd3;
  localparam logic [2:0] DISP_HOST     = 3'd4;
  localparam logic [2:0] DISP_CLEARED  = 3'd5;

  localparam logic [1:0] CLS_KNOWN   = 2'd0;
  localparam logic [1:0] CLS_UNKNOWN = 2'd1;
  localparam logic [1:0] CLS_MCAST   = 2'd2;
  localparam logic [1:0] CLS_BCAST   = 2'd3;

  localparam logic [2:0] LRN_UPDATED  = 3'd0;
  localparam logic [2:0] LRN_INSERTED = 3'd1;
  localparam logic [2:0] LRN_MCAST    = 3'd2;
  localparam logic [2:0] LRN_FULL     = 3'd3;
  localparam logic [2:0] LRN_NONE     = 3'd4;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_HOST  = 2'd1,
    KIND_CLEAR = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic             action;
    logic [1:0]       ingress_port;
    logic [MAC_W-1:0] source_mac;
    logic [MAC_W-1:0] dest_mac;
  } in_item_t;

  typedef struct packed {
    logic [2:0] disposition;
    logic [2:0] egress_mask;
    logic [1:0] dest_class;
    logic [2:0] learn_status;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    job_kind_t         kind;
    logic [1:0]        port;
    logic [VLAN_W-1:0] vlan;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic              src_mcast;
    logic [1:0]        dst_class;
    logic              dst_eq_src;
    logic [2:0]        flood;
  } job_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [VLAN_W-1:0] vlan;
    logic [1:0]        port;
  } entry_t;

  typedef struct packed {
    logic [VLAN_W-1:0] p0;
    logic [VLAN_W-1:0] p1;
    logic [VLAN_W-1:0] p2;
  } vlan_cfg_t;

endpackage

FILE: hdl/vlf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module vlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/vlf_front.sv
// front part: accepts input items, classifies them and queues the resulting jobs
// depends on vlf_pkg
`timescale 1ns / 1ps
module vlf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  vlf_pkg::in_item_t in_item,
  input  vlf_pkg::vlan_cfg_t vlan_cfg,
  output logic              job_valid,
  input  logic              job_pop,
  output vlf_pkg::job_t     job
);
  import vlf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t              q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W:0]    count;
  job_t              cls;
  logic [VLAN_W-1:0] vlan;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    unique case (in_item.ingress_port)
      2'd0:    vlan = vlan_cfg.p0;
      2'd1:    vlan = vlan_cfg.p1;
      default: vlan = vlan_cfg.p2;
    endcase
    cls = '0;
    cls.port = in_item.ingress_port;
    cls.vlan = vlan;
    cls.src = in_item.source_mac;
    cls.dst = in_item.dest_mac;
    cls.src_mcast = in_item.source_mac[40];
    cls.dst_eq_src = (in_item.dest_mac == in_item.source_mac);
    if (in_item.dest_mac == {MAC_W{1'b1}}) begin
      cls.dst_class = CLS_BCAST;
    end else if (in_item.dest_mac[40]) begin
      cls.dst_class = CLS_MCAST;
    end else begin
      cls.dst_class = CLS_KNOWN;
    end
    cls.flood[0] = (in_item.ingress_port != 2'd0) && (vlan_cfg.p0 == vlan);
    cls.flood[1] = (in_item.ingress_port != 2'd1) && (vlan_cfg.p1 == vlan);
    cls.flood[2] = (in_item.ingress_port != 2'd2) && (vlan_cfg.p2 == vlan);
    if (in_item.action) begin
      cls.kind = KIND_CLEAR;
    end else if (in_item.ingress_port == HOST_PORT) begin
      cls.kind = KIND_HOST;
    end else begin
      cls.kind = KIND_FRAME;
    end
  end

  assign full = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign job = q[rptr];
  assign do_push = push && !full;
  assign do_pop = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= cls;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

FILE: hdl/vlf_back.sv
// back part: scans the address table, learns the source, decides the forwarding,
// clears the table and holds the result item; depends on vlf_pkg and vlf_ram
`timescale 1ns / 1ps
module vlf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_pop,
  input  vlf_pkg::job_t       job,
  input  vlf_pkg::vlan_cfg_t  vlan_cfg,
  output logic                empty,
  input  logic                pop,
  output vlf_pkg::out_item_t  out_item
);
  import vlf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state;
  job_t                 cur;
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [IDX_W-1:0]     cnt;
  logic                 issuing;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic                 src_hit;
  logic [IDX_W-1:0]     src_idx;
  logic                 dst_hit;
  logic [1:0]           dst_port;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  out_item_t            res;
  out_item_t            done_res;
  out_item_t            res_next;
  logic                 out_valid;
  logic                 load_out;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;
  entry_t               rent;
  logic                 ent_ok;
  logic                 hit_eff;
  logic [1:0]           op;
  logic [VLAN_W-1:0]    op_vlan;

  vlf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt),
    .rdata(rent)
  );

  assign ent_ok = rd_vld && slot_valid[rd_idx] && (rent.vlan == cur.vlan);
  assign job_pop = (state == S_IDLE) && job_valid;
  assign load_out = (state == S_DONE) && (!out_valid || pop);
  assign empty = !out_valid;
  assign out_item = res;

  // learning and the write back happen together in the write step
  always_comb begin
    we = 1'b0;
    waddr = src_idx;
    wdata.mac = cur.src;
    wdata.vlan = cur.vlan;
    wdata.port = cur.port;
    res_next.learn_status = LRN_FULL;
    if (cur.src_mcast) begin
      res_next.learn_status = LRN_MCAST;
    end else if (src_hit) begin
      we = (state == S_WRITE);
      res_next.learn_status = LRN_UPDATED;
    end else if (free_found) begin
      we = (state == S_WRITE);
      waddr = free_idx;
      res_next.learn_status = LRN_INSERTED;
    end
    // a destination equal to the source sees the entry just learned
    hit_eff = dst_hit || (cur.dst_eq_src && !cur.src_mcast && free_found && !src_hit);
    op = cur.dst_eq_src ? cur.port : dst_port;
    unique case (op)
      2'd0:    op_vlan = vlan_cfg.p0;
      2'd1:    op_vlan = vlan_cfg.p1;
      default: op_vlan = vlan_cfg.p2;
    endcase
    res_next.disposition = DISP_FLOOD;
    res_next.egress_mask = cur.flood;
    res_next.dest_class = cur.dst_class;
    if (cur.dst_class == CLS_KNOWN) begin
      if (!hit_eff) begin
        res_next.dest_class = CLS_UNKNOWN;
      end else begin
        res_next.egress_mask = 3'd0;
        if (op == cur.port) begin
          res_next.disposition = DISP_SAMEPORT;
        end else if (op == HOST_PORT || op_vlan != cur.vlan) begin
          res_next.disposition = DISP_VLANDROP;
        end else begin
          res_next.disposition = DISP_FWD;
          res_next.egress_mask = 3'(1 << op);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      issuing <= 1'b0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        res <= done_res;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            unique case (job.kind)
              KIND_CLEAR: begin
                slot_valid <= '0;
                done_res <= '{DISP_CLEARED, 3'd0, CLS_KNOWN, LRN_NONE};
                state <= S_DONE;
              end
              KIND_HOST: begin
                done_res <= '{DISP_HOST, 3'd0, CLS_KNOWN, LRN_NONE};
                state <= S_DONE;
              end
              default: begin
                cnt <= '0;
                issuing <= 1'b1;
                src_hit <= 1'b0;
                dst_hit <= 1'b0;
                free_found <= 1'b0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_vld <= issuing;
          rd_idx <= cnt;
          if (issuing) begin
            if (cnt == IDX_W'(TABLE_ENTRIES-1)) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          if (ent_ok && rent.mac == cur.src) begin
            src_hit <= 1'b1;
            src_idx <= rd_idx;
          end
          if (ent_ok && rent.mac == cur.dst) begin
            dst_hit <= 1'b1;
            dst_port <= rent.port;
          end
          if (rd_vld && !slot_valid[rd_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx <= rd_idx;
          end
          // issuing is already low here, so rd_vld drops with the state change
          if (rd_vld && rd_idx == IDX_W'(TABLE_ENTRIES-1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (we) begin
            slot_valid[waddr] <= 1'b1;
          end
          done_res <= res_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || pop))
    else $error("result overwritten before taken");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (job_pop && job.kind == KIND_CLEAR) |=> (slot_valid == '0))
    else $error("table clear left valid slots");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_SCAN))
    else $error("table read data outside scan");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_WRITE) && !cur.src_mcast)
    else $error("table written outside learning");

endmodule

FILE: hdl/vlan_l2_learning_forwarder_top.sv
// top level of the vlan l2 learning forwarder: configuration registers, front and back
// depends on vlf_pkg, vlf_front, vlf_back, vlf_ram
//
// input items enter through push/full like a queue; the front classifies each item
// (table clear, host port or frame) and queues up to two jobs for the back.
// results leave through empty/pop: while empty is low the oldest result is on
// out_item and pop takes it. configuration is written through cfg_valid/cfg_ready
// (always ready) with cfg_index 0..2 selecting the access vlan of port 0..2;
// other indexes are ignored.
// a frame costs one full sweep of the address table through the memory read port;
// a table clear or a host port item skips the sweep and goes from idle straight to
// done in the back. the back takes a new job only once it is back in idle.
// reset empties the table at once (per-slot valid flops) and loads vlans 10, 10, 20.
// when the receiver stalls the result waits in the output register, the back
// holds the next result and the front queue fills, then full rises.
`timescale 1ns / 1ps
module vlan_l2_learning_forwarder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  vlf_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output vlf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import vlf_pkg::*;

  vlan_cfg_t vlan_cfg;
  logic      job_valid;
  logic      job_pop;
  job_t      job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_cfg.p0 <= PORT0_VLAN_RST;
      vlan_cfg.p1 <= PORT1_VLAN_RST;
      vlan_cfg.p2 <= PORT2_VLAN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PORT0_VLAN: vlan_cfg.p0 <= cfg_data;
        CFG_PORT1_VLAN: vlan_cfg.p1 <= cfg_data;
        CFG_PORT2_VLAN: vlan_cfg.p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  vlf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .vlan_cfg (vlan_cfg),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .job      (job)
  );

  vlf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .job      (job),
    .vlan_cfg (vlan_cfg),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
